// File: src/hpa_pkg.sv
// shared types, constants and codes for the hole allocator
`timescale 1ns / 1ps
`default_nettype none
package hpa_pkg;

	localparam int NUM_HOLES  = 8;
	localparam int SIZE_WIDTH = 16;

	localparam int IDX_W = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;
	localparam int CNT_W = $clog2(NUM_HOLES + 1);
	localparam int HIU_W = 4;
	localparam int CMP_W = (CNT_W > HIU_W) ? CNT_W : HIU_W;

	localparam logic [1:0] POLICY_FIRST = 2'd0;
	localparam logic [1:0] POLICY_BEST  = 2'd1;
	localparam logic [1:0] POLICY_WORST = 2'd2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	localparam logic REG_FIT_POLICY   = 1'b0;
	localparam logic REG_HOLES_IN_USE = 1'b1;

	localparam logic [HIU_W-1:0] HIU_RESET = HIU_W'(8);

	typedef logic [SIZE_WIDTH-1:0] size_t;
	typedef logic [IDX_W-1:0]      idx_t;

	typedef struct packed {
		logic found;
		logic best;
		logic worst;
	} scan_ctrl_t;

	typedef struct packed {
		logic fits;
		logic take;
	} scan_res_t;

endpackage
`default_nettype wire

// File: src/fit_policy_hole_allocator.sv
// top level: hole allocator with sequencer, config registers and output register
// a load goes from idle to done; an allocate goes idle, scan, done, skipping the scan with no holes in use
// a new beat is not taken until the last one has left done; first fit stops the scan at the first hole that fits
// the scan reads one hole a cycle through the shared compare unit
// in_ready is high only while idle; a finished result waits in the output register
// arst_n clears the sequencer, output valid and config (first fit, eight holes in use)
`timescale 1ns / 1ps
`default_nettype none
module fit_policy_hole_allocator
	import hpa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [2:0]  load_index,
	input  wire logic [15:0] amount,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             granted,
	output logic [2:0]       chosen_index,
	output logic [15:0]      size_before,
	output logic [15:0]      size_after
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [1:0]         policy_q;
	logic [HIU_W-1:0]   hiu_q;
	logic               req_q;
	logic [2:0]         lidx_q;
	size_t              amt_q;
	logic [CNT_W-1:0]   limit_q;
	idx_t               cnt_q;
	idx_t               pick_q;
	size_t              best_q;
	logic               found_q;
	logic               out_valid_q;
	logic               granted_q;
	logic [2:0]         chosen_q;
	logic [15:0]        before_q;
	logic [15:0]        after_q;

	logic [CMP_W-1:0]   hiu_ext;
	logic [CNT_W-1:0]   lim_d;
	logic               first_fit;
	logic               last_step;
	logic               done_fire;
	logic               load_ok;
	scan_ctrl_t         ctrl;
	scan_res_t          res;
	size_t              rd_data;
	size_t              diff;
	logic               wr_en;
	idx_t               wr_addr;
	size_t              wr_data;
	idx_t               rd_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_FIRST;
			hiu_q    <= HIU_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FIT_POLICY:   policy_q <= cfg_wdata[1:0];
				REG_HOLES_IN_USE: hiu_q    <= cfg_wdata[HIU_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		hiu_ext   = CMP_W'(hiu_q);
		lim_d     = (hiu_ext > CMP_W'(NUM_HOLES)) ? CNT_W'(NUM_HOLES) : CNT_W'(hiu_ext);
		ctrl.found = found_q;
		ctrl.best  = (policy_q == POLICY_BEST);
		ctrl.worst = (policy_q == POLICY_WORST);
		first_fit = !(ctrl.best || ctrl.worst);
		last_step = (CNT_W'(cnt_q) == (limit_q - CNT_W'(1)));
		done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		load_ok   = (32'(lidx_q) < NUM_HOLES);
	end

	hpa_scan_unit u_scan (
		.hole (rd_data),
		.amt  (amt_q),
		.best (best_q),
		.ctrl (ctrl),
		.res  (res),
		.diff (diff)
	);

	always_comb begin
		wr_en   = done_fire && (((req_q == REQ_LOAD) && load_ok) ||
			((req_q == REQ_ALLOC) && found_q));
		wr_addr = (req_q == REQ_LOAD) ? IDX_W'(lidx_q) : pick_q;
		wr_data = (req_q == REQ_LOAD) ? amt_q : diff;
	end

	// fetch the next hole while the current one is scanned, so its size is registered when the scan gets there
	assign rd_addr = (state_q == ST_SCAN) ? cnt_q + IDX_W'(1) : '0;

	hpa_hole_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						found_q <= 1'b0;
						if ((req_type == REQ_ALLOC) && (lim_d != '0)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (res.take) begin
						found_q <= 1'b1;
					end
					if (last_step || (res.take && first_fit)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_q   <= req_type;
					lidx_q  <= load_index;
					amt_q   <= SIZE_WIDTH'(amount);
					limit_q <= lim_d;
					cnt_q   <= '0;
				end
			end
			ST_SCAN: begin
				if (res.take) begin
					pick_q <= cnt_q;
					best_q <= rd_data;
				end
				if (!last_step) begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			if (req_q == REQ_LOAD) begin
				granted_q <= load_ok;
				chosen_q  <= lidx_q;
				before_q  <= load_ok ? 16'(amt_q) : '0;
				after_q   <= load_ok ? 16'(amt_q) : '0;
			end else if (found_q) begin
				granted_q <= 1'b1;
				chosen_q  <= 3'(pick_q);
				before_q  <= 16'(best_q);
				after_q   <= 16'(diff);
			end else begin
				granted_q <= 1'b0;
				chosen_q  <= '0;
				before_q  <= '0;
				after_q   <= '0;
			end
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign granted      = granted_q;
	assign chosen_index = chosen_q;
	assign size_before  = before_q;
	assign size_after   = after_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("allocator took a new beat while busy");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> CNT_W'(cnt_q) < limit_q)
		else $error("scan counter beyond holes in use");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !granted |-> size_before == '0 && size_after == '0)
		else $error("refused beat carries nonzero sizes");

	a_shrink_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> size_after <= size_before)
		else $error("granted hole grew");
`endif

endmodule
`default_nettype wire

// File: src/hpa_hole_table.sv
// register file of hole sizes, one read port and one write port
`timescale 1ns / 1ps
`default_nettype none
module hpa_hole_table
	import hpa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  wr_en,
	input  wire idx_t  wr_addr,
	input  wire size_t wr_data,
	input  wire idx_t  rd_addr,
	output size_t      rd_data
);

	size_t mem_q [NUM_HOLES];
	size_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// File: src/hpa_scan_unit.sv
// shared compare and subtract unit used by every scan step and the write-back
`timescale 1ns / 1ps
`default_nettype none
module hpa_scan_unit
	import hpa_pkg::*;
(
	input  wire size_t      hole,
	input  wire size_t      amt,
	input  wire size_t      best,
	input  wire scan_ctrl_t ctrl,
	output scan_res_t       res,
	output size_t           diff
);

	logic fits;
	logic better;

	always_comb begin
		fits   = (hole >= amt);
		better = (ctrl.best && (hole < best)) || (ctrl.worst && (hole > best));
		res.fits = fits;
		res.take = fits && (!ctrl.found || better);
	end

	assign diff = best - amt;

endmodule
`default_nettype wire
